@@ sv/rgbe_pkg.sv @@
// Shared constants and types for the RGBE shared-exponent encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package rgbe_pkg;

    localparam int FLT_W  = 32;
    localparam int BYTE_W = 8;
    localparam int EXP_W  = 8;
    localparam int MAN_W  = 23;
    localparam int SIG_W  = 24;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [EXP_W-1:0] EXP_TOP      = 8'hFE;
    localparam logic [EXP_W-1:0] EXP_BIAS_ADJ = 8'd2;

    // Smallest positive single whose value is at least 1e-32, sign bit removed.
    localparam logic [FLT_W-2:0] BLACK_LIMIT = 31'h0A4F_B11F;

    typedef struct packed {
        logic [BYTE_W-1:0] red_mantissa;
        logic [BYTE_W-1:0] green_mantissa;
        logic [BYTE_W-1:0] blue_mantissa;
        logic [BYTE_W-1:0] shared_exponent;
        logic              non_finite;
    } rgbe_word_t;

endpackage
`default_nettype wire

@@ sv/rgbe_chan.sv @@
// Scales one single-precision component by 255 * 2^-e and saturates it to a byte.
// Depends on rgbe_pkg.
`default_nettype none
module rgbe_chan
    import rgbe_pkg::*;
(
    input  wire logic [FLT_W-1:0]  comp,
    input  wire logic [EXP_W-1:0]  p_exp,
    output logic      [BYTE_W-1:0] byte_out
);

    logic [EXP_W-1:0]  ce;
    logic [EXP_W-1:0]  ce_eff;
    logic [SIG_W-1:0]  sig;
    logic [FLT_W-1:0]  prod;
    logic [4:0]        lz;
    logic [FLT_W-1:0]  norm;
    logic              guard;
    logic              sticky;
    logic              rnd;
    logic [SIG_W:0]    rounded;
    logic signed [10:0] shamt;
    logic [SIG_W:0]    whole;

    always_comb begin
        ce     = comp[FLT_W-2:MAN_W];
        ce_eff = (ce == '0) ? EXP_W'(1) : ce;
        sig    = {(ce != '0), comp[MAN_W-1:0]};
        prod   = {sig, 8'b0} - {8'b0, sig};
        lz     = '0;
        for (int i = 0; i < FLT_W; i++) begin
            if (prod[i]) begin
                lz = 5'(FLT_W - 1 - i);
            end
        end
        norm    = prod << lz;
        guard   = norm[7];
        sticky  = |norm[6:0];
        rnd     = guard & (sticky | norm[8]);
        rounded = {1'b0, norm[FLT_W-1:8]} + {{SIG_W{1'b0}}, rnd};
        shamt   = $signed({3'b0, p_exp}) + 11'sd16 + $signed({6'b0, lz})
                  - $signed({3'b0, ce_eff});
        whole   = rounded >> shamt[4:0];
        if (comp[FLT_W-1] || prod == '0 || shamt >= 11'sd25) begin
            byte_out = '0;
        end else if (shamt <= 11'sd0 || whole > (SIG_W+1)'(255)) begin
            byte_out = 8'hFF;
        end else begin
            byte_out = whole[BYTE_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ sv/rgbe_core.sv @@
// Combinational RGBE encode of one pixel: maximum, black test, exponent, three bytes.
// Depends on rgbe_pkg and rgbe_chan.
`default_nettype none
module rgbe_core
    import rgbe_pkg::*;
(
    input  wire logic [FLT_W-1:0] red_bits,
    input  wire logic [FLT_W-1:0] green_bits,
    input  wire logic [FLT_W-1:0] blue_bits,
    output rgbe_word_t            word
);

    logic [FLT_W-1:0] key_r, key_g, key_b;
    logic [FLT_W-1:0] max_rg, key_rg, max_p, key_p;
    logic             nf;
    logic             black;
    logic [BYTE_W-1:0] byte_r, byte_g, byte_b;

    function automatic logic [FLT_W-1:0] order_key(input logic [FLT_W-1:0] f);
        return f[FLT_W-1] ? ~f : {1'b1, f[FLT_W-2:0]};
    endfunction

    always_comb begin
        nf     = (red_bits[FLT_W-2:MAN_W] == EXP_ALL_ONES)
               | (green_bits[FLT_W-2:MAN_W] == EXP_ALL_ONES)
               | (blue_bits[FLT_W-2:MAN_W] == EXP_ALL_ONES);
        key_r  = order_key(red_bits);
        key_g  = order_key(green_bits);
        key_b  = order_key(blue_bits);
        max_rg = (key_r >= key_g) ? red_bits : green_bits;
        key_rg = (key_r >= key_g) ? key_r : key_g;
        max_p  = (key_rg >= key_b) ? max_rg : blue_bits;
        key_p  = (key_rg >= key_b) ? key_rg : key_b;
        black  = max_p[FLT_W-1] || (max_p[FLT_W-2:0] < BLACK_LIMIT);
    end

    rgbe_chan u_chan_r (.comp(red_bits),   .p_exp(max_p[FLT_W-2:MAN_W]), .byte_out(byte_r));
    rgbe_chan u_chan_g (.comp(green_bits), .p_exp(max_p[FLT_W-2:MAN_W]), .byte_out(byte_g));
    rgbe_chan u_chan_b (.comp(blue_bits),  .p_exp(max_p[FLT_W-2:MAN_W]), .byte_out(byte_b));

    always_comb begin
        word = '0;
        word.non_finite = nf;
        if (!nf && !black && key_p[FLT_W-1]) begin
            word.red_mantissa    = byte_r;
            word.green_mantissa  = byte_g;
            word.blue_mantissa   = byte_b;
            word.shared_exponent = (max_p[FLT_W-2:MAN_W] == EXP_TOP) ? 8'hFF
                                 : max_p[FLT_W-2:MAN_W] + EXP_BIAS_ADJ;
        end
    end

endmodule
`default_nettype wire

@@ sv/float_rgb_to_rgbe_encode.sv @@
// Top level of the RGBE encoder: input register, encode logic, result register.
// Depends on rgbe_pkg and rgbe_core.
//
// Converts one pixel of three IEEE-754 single components into an RGBE word. The
// block is a two-register pipeline: a transaction accepted into the input
// register is encoded from there and moves into the result register once that
// register is empty or being read, and one pixel is accepted every cycle while
// the result side takes them. The critical path is the float maximum, a
// 32-bit leading-zero search and the byte shift in each component lane.
// Non-finite components raise m_non_finite with all bytes zero.
`default_nettype none
module float_rgb_to_rgbe_encode
    import rgbe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FLT_W-1:0]  s_red_bits,
    input  wire logic [FLT_W-1:0]  s_green_bits,
    input  wire logic [FLT_W-1:0]  s_blue_bits,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_red_mantissa,
    output logic      [BYTE_W-1:0] m_green_mantissa,
    output logic      [BYTE_W-1:0] m_blue_mantissa,
    output logic      [BYTE_W-1:0] m_shared_exponent,
    output logic                   m_non_finite
);

    logic             in_valid_reg, in_valid_next;
    logic [FLT_W-1:0] red_reg, green_reg, blue_reg;
    logic             out_valid_reg, out_valid_next;
    rgbe_word_t       word_reg;
    rgbe_word_t       word;
    logic             advance;

    rgbe_core u_core (
        .red_bits  (red_reg),
        .green_bits(green_reg),
        .blue_bits (blue_reg),
        .word      (word)
    );

    always_comb begin
        advance        = !out_valid_reg || m_ready;
        s_ready        = !in_valid_reg || advance;
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            red_reg   <= s_red_bits;
            green_reg <= s_green_bits;
            blue_reg  <= s_blue_bits;
        end
        if (advance && in_valid_reg) begin
            word_reg <= word;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_red_mantissa    = word_reg.red_mantissa;
    assign m_green_mantissa  = word_reg.green_mantissa;
    assign m_blue_mantissa   = word_reg.blue_mantissa;
    assign m_shared_exponent = word_reg.shared_exponent;
    assign m_non_finite      = word_reg.non_finite;

endmodule
`default_nettype wire

@@ sv/rgbe_checker.sv @@
// Port-level assertions for the RGBE encoder, attached by bind.
// Depends on rgbe_pkg and float_rgb_to_rgbe_encode.
`default_nettype none
module rgbe_checker
    import rgbe_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [BYTE_W-1:0] m_red_mantissa,
    input wire logic [BYTE_W-1:0] m_green_mantissa,
    input wire logic [BYTE_W-1:0] m_blue_mantissa,
    input wire logic [BYTE_W-1:0] m_shared_exponent,
    input wire logic              m_non_finite
);

    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_non_finite |-> m_red_mantissa == '0 && m_green_mantissa == '0
            && m_blue_mantissa == '0 && m_shared_exponent == '0)
        else $error("non-finite transaction carries nonzero bytes");

    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_shared_exponent == '0 |-> m_red_mantissa == '0
            && m_green_mantissa == '0 && m_blue_mantissa == '0)
        else $error("black transaction carries nonzero mantissas");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shared_exponent))
        else $error("stalled result dropped or changed");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

endmodule

bind float_rgb_to_rgbe_encode rgbe_checker u_rgbe_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_red_mantissa   (m_red_mantissa),
    .m_green_mantissa (m_green_mantissa),
    .m_blue_mantissa  (m_blue_mantissa),
    .m_shared_exponent(m_shared_exponent),
    .m_non_finite     (m_non_finite)
);
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for float_rgb_to_rgbe_encode: random and directed pixels
// pass through a valid/ready driver and monitor and are checked against a bit-level encoder.
// Depends on rgbe_pkg and the float_rgb_to_rgbe_encode RTL.
`default_nettype none
module testbench;
    import rgbe_pkg::*;

    localparam int NUM_RANDOM = 1950;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [FLT_W-1:0] red;
        logic [FLT_W-1:0] green;
        logic [FLT_W-1:0] blue;
    } pixel_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [FLT_W-1:0]  s_red_bits = '0;
    logic [FLT_W-1:0]  s_green_bits = '0;
    logic [FLT_W-1:0]  s_blue_bits = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_red_mantissa;
    logic [BYTE_W-1:0] m_green_mantissa;
    logic [BYTE_W-1:0] m_blue_mantissa;
    logic [BYTE_W-1:0] m_shared_exponent;
    logic              m_non_finite;

    float_rgb_to_rgbe_encode uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_bits(s_red_bits), .s_green_bits(s_green_bits), .s_blue_bits(s_blue_bits),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_mantissa(m_red_mantissa), .m_green_mantissa(m_green_mantissa),
        .m_blue_mantissa(m_blue_mantissa), .m_shared_exponent(m_shared_exponent),
        .m_non_finite(m_non_finite)
    );

    pixel_t     pixel_queue[$];
    rgbe_word_t rgbe_expected[$];
    int         errors = 0;
    int         n_sent = 0;
    int         n_recv = 0;
    int         n_nonfinite = 0;
    int         n_black = 0;
    int         src_gap = 0;
    int         sink_hold = 0;
    bit         did_stall = 1'b0;
    int         idle_cycles = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] order_key(logic [31:0] x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    function automatic logic [7:0] lane_byte(logic [31:0] c, int e);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int ce;
        int sh;
        int n;
        int d;
        if (c[31] || c[30:0] == '0) return 8'd0;
        if (c[30:23] == '0) begin
            q = {41'd0, c[22:0]};
            ce = 1;
        end else begin
            q = {40'd0, 1'b1, c[22:0]};
            ce = int'(c[30:23]);
        end
        q = q * 64'd255;
        sh = ce - 150 - e;
        n = 0;
        for (int i = 0; i < 64; i++) if (q[i]) n = i;
        if (n > 23) begin
            d = n - 23;
            rem = q & ((64'd1 << d) - 64'd1);
            half = 64'd1 << (d - 1);
            q = q >> d;
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            sh = sh + d;
        end
        if (sh >= 0) begin
            if (sh >= 9) return 8'd255;
            q = q << sh;
        end else begin
            if (-sh >= 63) return 8'd0;
            q = q >> (-sh);
        end
        return (q >= 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic rgbe_word_t encode_pixel(pixel_t px);
        rgbe_word_t w;
        logic [31:0] p;
        int e;
        w = '0;
        if (px.red[30:23] == EXP_ALL_ONES || px.green[30:23] == EXP_ALL_ONES
                || px.blue[30:23] == EXP_ALL_ONES) begin
            w.non_finite = 1'b1;
            return w;
        end
        p = px.red;
        if (!(order_key(p) >= order_key(px.green))) p = px.green;
        if (!(order_key(p) >= order_key(px.blue))) p = px.blue;
        if (p[31] || p[30:0] < BLACK_LIMIT) return w;
        e = int'(p[30:23]) - 126;
        w.red_mantissa = lane_byte(px.red, e);
        w.green_mantissa = lane_byte(px.green, e);
        w.blue_mantissa = lane_byte(px.blue, e);
        w.shared_exponent = (e > 127) ? 8'd255 : 8'(e + 128);
        return w;
    endfunction

    function automatic logic [31:0] near_float(int base_exp);
        int ex;
        ex = base_exp + $urandom_range(0, 12) - 6;
        if (ex < 0) ex = 0;
        if (ex > 254) ex = 254;
        return {($urandom_range(0, 9) == 0), 8'(ex), 23'($urandom)};
    endfunction

    task automatic add_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        pixel_queue.push_back('{red: r, green: g, blue: b});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                rgbe_expected.push_back(encode_pixel('{red: s_red_bits,
                    green: s_green_bits, blue: s_blue_bits}));
                n_sent <= n_sent + 1;
            end
            if (s_valid && !s_ready) begin
                // hold the offered transaction
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_red_bits <= pixel_queue[0].red;
                s_green_bits <= pixel_queue[0].green;
                s_blue_bits <= pixel_queue[0].blue;
                void'(pixel_queue.pop_front());
                s_valid <= 1'b1;
                src_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_recv <= n_recv + 1;
                if (rgbe_expected.size() == 0) begin
                    $error("unexpected result transaction");
                    errors = errors + 1;
                end else begin
                    if (m_red_mantissa !== rgbe_expected[0].red_mantissa) begin
                        $error("red_mantissa exp %0d got %0d",
                            rgbe_expected[0].red_mantissa, m_red_mantissa);
                        errors = errors + 1;
                    end
                    if (m_green_mantissa !== rgbe_expected[0].green_mantissa) begin
                        $error("green_mantissa exp %0d got %0d",
                            rgbe_expected[0].green_mantissa, m_green_mantissa);
                        errors = errors + 1;
                    end
                    if (m_blue_mantissa !== rgbe_expected[0].blue_mantissa) begin
                        $error("blue_mantissa exp %0d got %0d",
                            rgbe_expected[0].blue_mantissa, m_blue_mantissa);
                        errors = errors + 1;
                    end
                    if (m_shared_exponent !== rgbe_expected[0].shared_exponent) begin
                        $error("shared_exponent exp %0d got %0d",
                            rgbe_expected[0].shared_exponent, m_shared_exponent);
                        errors = errors + 1;
                    end
                    if (m_non_finite !== rgbe_expected[0].non_finite) begin
                        $error("non_finite exp %0d got %0d",
                            rgbe_expected[0].non_finite, m_non_finite);
                        errors = errors + 1;
                    end
                    if (rgbe_expected[0].non_finite) n_nonfinite <= n_nonfinite + 1;
                    else if (rgbe_expected[0].shared_exponent == '0) n_black <= n_black + 1;
                    void'(rgbe_expected.pop_front());
                end
            end
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_ready <= 1'b0;
            end else if (!did_stall && n_recv >= 500) begin
                did_stall <= 1'b1;
                sink_hold <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 9) < 7) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                sink_hold <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int base;
        int k;
        add_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_pixel(32'h8000_0000, 32'hBF80_0000, 32'hFF7F_FFFF);
        add_pixel(32'h3F80_0000, 32'h3F00_0000, 32'h3E80_0000);
        add_pixel(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        add_pixel(32'h3F80_0000, 32'hFF80_0000, 32'h3F80_0000);
        add_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0001);
        add_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        add_pixel(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F00_0000);
        add_pixel(32'h7F00_0000, 32'h3F80_0000, 32'h8000_0001);
        add_pixel({1'b0, BLACK_LIMIT}, 32'h0000_0001, 32'h0000_0000);
        add_pixel({1'b0, BLACK_LIMIT - 31'd1}, 32'h0000_0001, 32'h0000_0000);
        add_pixel({1'b0, BLACK_LIMIT}, {1'b0, BLACK_LIMIT}, 32'h8000_0000);
        add_pixel(32'h3F7F_FFFF, 32'h3F7F_FFFF, 32'h3F7F_FFFF);
        add_pixel(32'h3F7F_FFFF, 32'h3F7F_FFFE, 32'h3F00_0000);
        add_pixel(32'h007F_FFFF, 32'h0000_0001, 32'h0080_0000);
        add_pixel(32'h4B7F_FFFF, 32'h4B00_0001, 32'h3F80_0000);
        add_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        add_pixel(32'h3F40_0000, 32'hBF40_0000, 32'h3B00_0000);
        add_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h2AAA_AAAA);
        add_pixel(32'h4000_0000, 32'h7F7F_FFFF, 32'h0000_0000);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            k = $urandom_range(0, 99);
            base = $urandom_range(0, 254);
            if (k < 15) add_pixel($urandom, $urandom, $urandom);
            else if (k < 20) add_pixel(near_float(base), {1'b0, EXP_ALL_ONES, 23'($urandom)},
                near_float(base));
            else if (k < 25) add_pixel(near_float(20), near_float(20), near_float(20));
            else add_pixel(near_float(base), near_float(base), near_float(base));
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pixel_queue.size() == 0);
        @(posedge aclk);
        wait (!s_valid);
        wait (rgbe_expected.size() == 0);
        repeat (10) @(posedge aclk);
        $display("encoded %0d pixels, %0d results checked (%0d non-finite, %0d black)",
            n_sent, n_recv, n_nonfinite, n_black);
        $display("random gaps on both sides plus one long result-side stall");
        if (errors == 0 && rgbe_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ float_rgb_to_rgbe_encode.f @@
sv/rgbe_pkg.sv
sv/rgbe_chan.sv
sv/rgbe_core.sv
sv/float_rgb_to_rgbe_encode.sv
sv/rgbe_checker.sv
tb/testbench.sv
